@@ hdl/lbc_pkg.sv @@
// Shared types and constants of the layer blend compositor.
package lbc_pkg;

  localparam int NUM_LAYERS_MAX = 3;
  localparam int NUM_CH         = 3;
  localparam int CH_W           = 8;
  localparam int MODE_W         = 3;
  localparam int ALPHA_W        = 7;
  localparam int CFG_INDEX_W    = 3;
  localparam int CFG_DATA_W     = ALPHA_W;

  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;

  localparam logic [ALPHA_W-1:0] ALPHA_FULL = 7'd100;

  localparam logic [CFG_INDEX_W-1:0] REG_MODE_LAYER0  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MODE_LAYER1  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MODE_LAYER2  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_LAYER0 = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_LAYER1 = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_LAYER2 = 3'd5;

  typedef enum logic [MODE_W-1:0] {
    MODE_NORMAL   = 3'd0,
    MODE_AVERAGE  = 3'd1,
    MODE_MULTIPLY = 3'd2,
    MODE_SCREEN   = 3'd3,
    MODE_DARKEN   = 3'd4,
    MODE_LIGHTEN  = 3'd5
  } blend_mode_t;

  typedef logic [NUM_CH-1:0][CH_W-1:0] pixel_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [ALPHA_W-1:0] alpha;
  } cfg_layer_t;

endpackage

@@ hdl/lbc_if.sv @@
// Stream interfaces for the layer pixels and the composited pixel.
interface lbc_layers_if;
  logic       valid;
  logic       ready;
  logic [7:0] l0_red;
  logic [7:0] l0_green;
  logic [7:0] l0_blue;
  logic [7:0] l1_red;
  logic [7:0] l1_green;
  logic [7:0] l1_blue;
  logic [7:0] l2_red;
  logic [7:0] l2_green;
  logic [7:0] l2_blue;

  modport source (
    output valid, l0_red, l0_green, l0_blue, l1_red, l1_green, l1_blue,
           l2_red, l2_green, l2_blue,
    input  ready
  );
  modport sink (
    input  valid, l0_red, l0_green, l0_blue, l1_red, l1_green, l1_blue,
           l2_red, l2_green, l2_blue,
    output ready
  );
endinterface

interface lbc_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;

  modport source (output valid, out_red, out_green, out_blue, input ready);
  modport sink (input valid, out_red, out_green, out_blue, output ready);
endinterface

@@ hdl/lbc_cell.sv @@
// One compositing cell: blends one layer onto the running base in three stages.
module lbc_cell #(
  parameter int LAYERS = 3,
  parameter int IDX    = 0
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  lbc_pkg::cfg_layer_t               cfg,
  input  logic                              valid_in,
  input  lbc_pkg::pixel_t                   base_in,
  input  lbc_pkg::pixel_t [LAYERS-1:0]      px_in,
  output logic                              valid_out,
  output lbc_pkg::pixel_t                   base_out,
  output lbc_pkg::pixel_t [LAYERS-1:0]      px_out
);
  import lbc_pkg::*;

  // floor(s / 100) == (s * 5243) >> 19 for every s up to 25500.
  localparam logic [12:0] DIV100_RECIP = 13'd5243;
  localparam int          DIV100_SHIFT = 19;

  function automatic logic [CH_W-1:0] blend(logic [MODE_W-1:0] mode,
                                            logic [CH_W-1:0] b,
                                            logic [CH_W-1:0] p);
    logic              scr;
    logic [CH_W-1:0]   ma;
    logic [CH_W-1:0]   mb;
    logic [2*CH_W-1:0] prod;
    logic [CH_W:0]     sum;
    logic [CH_W-1:0]   res;
    scr  = (blend_mode_t'(mode) == MODE_SCREEN);
    // Multiply and screen share one multiplier; 255 - v is ~v on a byte.
    ma   = scr ? ~b : b;
    mb   = scr ? ~p : p;
    prod = ma * mb;
    sum  = {1'b0, b} + {1'b0, p};
    case (blend_mode_t'(mode))
      MODE_AVERAGE:  res = sum[CH_W:1];
      MODE_MULTIPLY: res = prod[2*CH_W-1:CH_W];
      MODE_SCREEN:   res = ~prod[2*CH_W-1:CH_W];
      MODE_DARKEN:   res = (b < p) ? b : p;
      MODE_LIGHTEN:  res = (b > p) ? b : p;
      default:       res = p;
    endcase
    return res;
  endfunction

  logic                         v1, v2, v3;
  pixel_t                       b1, x1, base3;
  logic [ALPHA_W-1:0]           a1;
  logic [NUM_CH-1:0][14:0]      s2;
  pixel_t [LAYERS-1:0]          px1, px2, px3;

  pixel_t                       x_next;
  logic [ALPHA_W-1:0]           a_next;
  logic [NUM_CH-1:0][14:0]      s_next;
  pixel_t                       q_next;
  logic [27:0]                  q_prod;

  always_comb begin
    a_next = (cfg.alpha > ALPHA_FULL) ? ALPHA_FULL : cfg.alpha;
    q_prod = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      x_next[c] = blend(cfg.mode, base_in[c], px_in[IDX][c]);
      s_next[c] = 15'(b1[c]) * 15'(ALPHA_FULL - a1) + 15'(x1[c]) * 15'(a1);
      q_prod    = 28'(s2[c]) * 28'(DIV100_RECIP);
      q_next[c] = q_prod[DIV100_SHIFT+CH_W-1:DIV100_SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= valid_in;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1    <= base_in;
      x1    <= x_next;
      a1    <= a_next;
      px1   <= px_in;
      s2    <= s_next;
      px2   <= px1;
      base3 <= q_next;
      px3   <= px2;
    end
  end

  assign valid_out = v3;
  assign base_out  = base3;
  assign px_out    = px3;

endmodule

@@ hdl/layer_blend_compositor_unit.sv @@
// Top level of the layer blend compositor: config registers and the cell chain.
// Throughput: one pixel per clock while the output is not stalled.
// Each cell has a blend, a mix and a divide stage.
// A stalled result holds the whole chain, so input is taken whenever output moves.
// Reset clears every stage valid bit and sets all layers to normal mode, opacity 100.
module layer_blend_compositor_unit #(
  parameter int LAYER_COUNT = 3
) (
  input  logic                              clk,
  input  logic                              rst,
  lbc_layers_if.sink                        layers,
  lbc_result_if.source                      result,
  input  logic                              cfg_we,
  input  logic [lbc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [lbc_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import lbc_pkg::*;

  // Per-layer mode and opacity. Writes to indexes beyond the last register
  // fall through the decoder and change nothing.
  cfg_layer_t [NUM_LAYERS_MAX-1:0] cfg_regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LAYERS_MAX; i++) begin
        cfg_regs[i].mode  <= MODE_NORMAL;
        cfg_regs[i].alpha <= ALPHA_FULL;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE_LAYER0:  cfg_regs[0].mode  <= cfg_data[MODE_W-1:0];
        REG_MODE_LAYER1:  cfg_regs[1].mode  <= cfg_data[MODE_W-1:0];
        REG_MODE_LAYER2:  cfg_regs[2].mode  <= cfg_data[MODE_W-1:0];
        REG_ALPHA_LAYER0: cfg_regs[0].alpha <= cfg_data;
        REG_ALPHA_LAYER1: cfg_regs[1].alpha <= cfg_data;
        REG_ALPHA_LAYER2: cfg_regs[2].alpha <= cfg_data;
        default: ;
      endcase
    end
  end

  // Gather the input transaction into one pixel per layer. Only the first
  // LAYER_COUNT layers travel down the chain.
  pixel_t [NUM_LAYERS_MAX-1:0] all_px;
  pixel_t [LAYER_COUNT-1:0]    layer_px;

  always_comb begin
    all_px[0][CH_RED]   = layers.l0_red;
    all_px[0][CH_GREEN] = layers.l0_green;
    all_px[0][CH_BLUE]  = layers.l0_blue;
    all_px[1][CH_RED]   = layers.l1_red;
    all_px[1][CH_GREEN] = layers.l1_green;
    all_px[1][CH_BLUE]  = layers.l1_blue;
    all_px[2][CH_RED]   = layers.l2_red;
    all_px[2][CH_GREEN] = layers.l2_green;
    all_px[2][CH_BLUE]  = layers.l2_blue;
  end

  assign layer_px = all_px[LAYER_COUNT-1:0];

  // The whole chain advances together whenever the output register is empty
  // or its transaction completes this cycle. The last cell's stage is the
  // output register, so a waiting result freezes every stage, empty ones
  // included, and the input waits along with it.
  logic advance;
  assign advance      = !result.valid || result.ready;
  assign layers.ready = advance;

  logic   [LAYER_COUNT:0]   chain_valid;
  pixel_t [LAYER_COUNT:0]   chain_base;
  pixel_t [LAYER_COUNT-1:0] chain_px [LAYER_COUNT+1];

  // Compositing starts from a black base.
  assign chain_valid[0] = layers.valid;
  assign chain_base[0]  = '0;
  assign chain_px[0]    = layer_px;

  for (genvar k = 0; k < LAYER_COUNT; k++) begin : g_cell
    lbc_cell #(
      .LAYERS (LAYER_COUNT),
      .IDX    (k)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (advance),
      .cfg       (cfg_regs[k]),
      .valid_in  (chain_valid[k]),
      .base_in   (chain_base[k]),
      .px_in     (chain_px[k]),
      .valid_out (chain_valid[k+1]),
      .base_out  (chain_base[k+1]),
      .px_out    (chain_px[k+1])
    );
  end

  assign result.valid     = chain_valid[LAYER_COUNT];
  assign result.out_red   = chain_base[LAYER_COUNT][CH_RED];
  assign result.out_green = chain_base[LAYER_COUNT][CH_GREEN];
  assign result.out_blue  = chain_base[LAYER_COUNT][CH_BLUE];

  // Reset empties the pipeline, so no result is offered right after it.
  a_reset_empty: assert property (@(posedge clk) rst |=> !result.valid)
    else $error("result valid right after reset");

  // Input is held off only while a finished result is waiting.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !layers.ready |-> result.valid)
    else $error("input stalled with no result pending");

  // A write beyond the register list must leave the configuration untouched.
  a_cfg_range: assert property (@(posedge clk) disable iff (rst)
    (cfg_we && (cfg_index > REG_ALPHA_LAYER2)) |=> $stable(cfg_regs))
    else $error("out-of-range config write changed a register");

endmodule

@@ sim/tb_layer_blend_compositor_unit.sv @@
// Self-checking testbench that streams layer pixels and checks every composited pixel.
module tb_layer_blend_compositor_unit;
  import lbc_pkg::*;

  // The block is built with all three layers. The expected values below
  // composite the same number of layers.
  localparam int LAYER_COUNT = 3;

  localparam int CLK_PERIOD     = 20;
  localparam int TIMEOUT_CYCLES = 200000;
  localparam int CH_MAX         = 255;
  localparam int RANDOM_PHASES  = 13;
  localparam int PHASE_PIXELS   = 100;

  // The register port has three index bits, so two indexes lie past the last
  // register. Writes to them must leave every layer setting alone.
  localparam logic [CFG_INDEX_W-1:0] REG_NONE_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_NONE_HI = 3'd7;

  // The receiver picks up a long hold-off when the accepted pixel count
  // reaches each of these marks. That backs up the pipeline into the input.
  localparam int HOLD_FIRST_AT  = 300;
  localparam int HOLD_SECOND_AT = 900;
  localparam int HOLD_CYCLES    = 90;

  // Three layer pixels, indexed [layer][channel].
  typedef pixel_t [NUM_LAYERS_MAX-1:0] layer_set_t;

  // These are the ready patterns of the result receiver.
  typedef enum logic [1:0] {
    RX_STREAM,
    RX_HALF,
    RX_SPARSE,
    RX_ALTERNATE
  } rx_style_t;

  logic clk;
  logic rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  lbc_layers_if layers_if ();
  lbc_result_if result_if ();

  layer_blend_compositor_unit #(
    .LAYER_COUNT(LAYER_COUNT)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .layers   (layers_if),
    .result   (result_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // This is our own copy of the layer settings. It changes only while the
  // pipeline is empty, so a pixel is always predicted with the settings that
  // the block applies to it.
  logic [MODE_W-1:0]  mode_sh  [NUM_LAYERS_MAX];
  logic [ALPHA_W-1:0] alpha_sh [NUM_LAYERS_MAX];

  layer_set_t pending_px_q [$];    // pixels waiting to be offered
  pixel_t     expected_px_q [$];   // composited pixels still owed by the block

  layer_set_t offered_px;
  layer_set_t taken_px;
  pixel_t     owed_px;

  int  pixels_queued;
  int  pixels_in;
  int  pixels_out;
  int  settings_cnt;
  int  field_errors;
  int  stray_results;
  bit  px_taken;
  bit  offering;
  int  burst_left;
  int  gap_left;
  int  hold_left;
  int  holds_done;
  int  style_left;
  rx_style_t rx_style;

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // Each channel starts from a black base and passes through the layers in
  // order. The layer mode blends the base with the layer value. The layer
  // opacity then mixes the blend back into the base as a truncated percentage.
  // Mode codes past lighten act as normal, and an opacity above full counts
  // as full.
  function automatic pixel_t composite_pixel(layer_set_t px);
    pixel_t acc;
    int     b;
    int     p;
    int     x;
    int     a;
    acc = '0;
    for (int l = 0; l < LAYER_COUNT; l++) begin
      for (int c = 0; c < NUM_CH; c++) begin
        b = int'(acc[c]);
        p = int'(px[l][c]);
        case (blend_mode_t'(mode_sh[l]))
          MODE_AVERAGE:  x = (b + p) >> 1;
          MODE_MULTIPLY: x = (b * p) >> 8;
          MODE_SCREEN:   x = CH_MAX - (((CH_MAX - b) * (CH_MAX - p)) >> 8);
          MODE_DARKEN:   x = (b < p) ? b : p;
          MODE_LIGHTEN:  x = (b > p) ? b : p;
          default:       x = p;
        endcase
        a = (alpha_sh[l] > ALPHA_FULL) ? int'(ALPHA_FULL) : int'(alpha_sh[l]);
        acc[c] = CH_W'((b * (int'(ALPHA_FULL) - a) + x * a) / int'(ALPHA_FULL));
      end
    end
    return acc;
  endfunction

  // Random channel values lean toward the two extremes now and then.
  function automatic logic [CH_W-1:0] rand_channel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return CH_W'($urandom);
    endcase
  endfunction

  function automatic layer_set_t rand_layers();
    layer_set_t px;
    for (int l = 0; l < NUM_LAYERS_MAX; l++)
      for (int c = 0; c < NUM_CH; c++)
        px[l][c] = rand_channel();
    return px;
  endfunction

  // Each layer is flat gray, with every channel of layer l set to the same value.
  function automatic layer_set_t flat_layers(logic [CH_W-1:0] v0, logic [CH_W-1:0] v1,
                                             logic [CH_W-1:0] v2);
    layer_set_t px;
    px[0] = {NUM_CH{v0}};
    px[1] = {NUM_CH{v1}};
    px[2] = {NUM_CH{v2}};
    return px;
  endfunction

  task automatic queue_pixel(layer_set_t px);
    pending_px_q.push_back(px);
    pixels_queued++;
  endtask

  // The task is called on a falling edge. The register takes the value at the next rising edge.
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx <= REG_MODE_LAYER2)
      mode_sh[2'(idx)] = data[MODE_W-1:0];
    else if (idx <= REG_ALPHA_LAYER2)
      alpha_sh[2'(idx - REG_ALPHA_LAYER0)] = data;
    @(negedge clk);
  endtask

  // Every register is rewritten for a new setting. A write to an unused index
  // with random data follows, and it must not disturb anything.
  task automatic set_layers(logic [CFG_DATA_W-1:0] m0, logic [CFG_DATA_W-1:0] a0,
                            logic [CFG_DATA_W-1:0] m1, logic [CFG_DATA_W-1:0] a1,
                            logic [CFG_DATA_W-1:0] m2, logic [CFG_DATA_W-1:0] a2);
    write_reg(REG_MODE_LAYER0, m0);
    write_reg(REG_ALPHA_LAYER0, a0);
    write_reg(REG_MODE_LAYER1, m1);
    write_reg(REG_ALPHA_LAYER1, a1);
    write_reg(REG_MODE_LAYER2, m2);
    write_reg(REG_ALPHA_LAYER2, a2);
    write_reg($urandom_range(0, 1) ? REG_NONE_HI : REG_NONE_LO, CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
    settings_cnt++;
  endtask

  // Mode data keeps random upper bits, which the register must drop. The
  // opacity is full, zero, saturating or anything in range.
  task automatic random_setting();
    logic [CFG_DATA_W-1:0] mode_data  [NUM_LAYERS_MAX];
    logic [CFG_DATA_W-1:0] alpha_data [NUM_LAYERS_MAX];
    for (int l = 0; l < NUM_LAYERS_MAX; l++) begin
      mode_data[l] = {4'($urandom), 3'($urandom)};
      case ($urandom_range(0, 4))
        0:       alpha_data[l] = '0;
        1:       alpha_data[l] = ALPHA_FULL;
        2:       alpha_data[l] = CFG_DATA_W'($urandom_range(101, 127));
        default: alpha_data[l] = CFG_DATA_W'($urandom_range(0, 100));
      endcase
    end
    set_layers(mode_data[0], alpha_data[0], mode_data[1], alpha_data[1],
               mode_data[2], alpha_data[2]);
  endtask

  // The counters only change on rising edges. A falling edge therefore sees
  // them settled. Every pixel yields exactly one result, so an empty
  // expectation queue means the pipeline is empty.
  task automatic wait_idle();
    do
      @(negedge clk);
    while (pixels_in != pixels_queued || expected_px_q.size() != 0);
  endtask

  // This block drives the layer input. It offers pixels in bursts of random
  // length with random gaps between them, and sometimes in long bursts with
  // no gaps. A pixel stays on the bus until the input monitor sees its
  // transaction.
  always @(negedge clk) begin
    if (rst) begin
      layers_if.valid <= 1'b0;
    end else begin
      if (px_taken) begin
        px_taken = 1'b0;
        offering = 1'b0;
      end
      if (!offering) begin
        if (gap_left > 0) begin
          gap_left--;
          layers_if.valid <= 1'b0;
        end else if (pending_px_q.size() > 0) begin
          offered_px = pending_px_q.pop_front();
          layers_if.l0_red   <= offered_px[0][CH_RED];
          layers_if.l0_green <= offered_px[0][CH_GREEN];
          layers_if.l0_blue  <= offered_px[0][CH_BLUE];
          layers_if.l1_red   <= offered_px[1][CH_RED];
          layers_if.l1_green <= offered_px[1][CH_GREEN];
          layers_if.l1_blue  <= offered_px[1][CH_BLUE];
          layers_if.l2_red   <= offered_px[2][CH_RED];
          layers_if.l2_green <= offered_px[2][CH_GREEN];
          layers_if.l2_blue  <= offered_px[2][CH_BLUE];
          layers_if.valid    <= 1'b1;
          offering = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 250)
                                                     : $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          layers_if.valid <= 1'b0;
        end
      end
    end
  end

  // The input monitor predicts each accepted pixel from the values that were
  // on the bus at the transaction.
  always @(posedge clk) begin
    if (!rst && layers_if.valid && layers_if.ready) begin
      taken_px[0][CH_RED]   = layers_if.l0_red;
      taken_px[0][CH_GREEN] = layers_if.l0_green;
      taken_px[0][CH_BLUE]  = layers_if.l0_blue;
      taken_px[1][CH_RED]   = layers_if.l1_red;
      taken_px[1][CH_GREEN] = layers_if.l1_green;
      taken_px[1][CH_BLUE]  = layers_if.l1_blue;
      taken_px[2][CH_RED]   = layers_if.l2_red;
      taken_px[2][CH_GREEN] = layers_if.l2_green;
      taken_px[2][CH_BLUE]  = layers_if.l2_blue;
      expected_px_q.push_back(composite_pixel(taken_px));
      pixels_in++;
      px_taken = 1'b1;
    end
  end

  // This block drives ready on the result side. It switches between a few
  // ready patterns every so often. Twice in the run it holds ready low for
  // a long stretch, so that the pipeline fills and the input is refused.
  always @(negedge clk) begin
    if (rst) begin
      result_if.ready <= 1'b0;
    end else begin
      if (hold_left == 0 &&
          ((holds_done == 0 && pixels_in >= HOLD_FIRST_AT) ||
           (holds_done == 1 && pixels_in >= HOLD_SECOND_AT))) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_if.ready <= 1'b0;
      end else begin
        if (style_left == 0) begin
          rx_style   = rx_style_t'($urandom_range(0, 3));
          style_left = $urandom_range(16, 160);
        end else begin
          style_left--;
        end
        case (rx_style)
          RX_STREAM:    result_if.ready <= 1'b1;
          RX_HALF:      result_if.ready <= 1'($urandom);
          RX_SPARSE:    result_if.ready <= ($urandom_range(0, 3) == 0);
          RX_ALTERNATE: result_if.ready <= style_left[0];
          default:      result_if.ready <= 1'b1;
        endcase
      end
    end
  end

  // The output monitor matches each result transaction with the oldest expected pixel.
  always @(posedge clk) begin
    if (!rst && result_if.valid && result_if.ready) begin
      if (expected_px_q.size() == 0) begin
        $error("composited pixel %0d/%0d/%0d arrived with none expected",
               result_if.out_red, result_if.out_green, result_if.out_blue);
        stray_results++;
      end else begin
        owed_px = expected_px_q.pop_front();
        pixels_out++;
        if (result_if.out_red !== owed_px[CH_RED]) begin
          $error("out_red: expected %0d, actual %0d", owed_px[CH_RED], result_if.out_red);
          field_errors++;
        end
        if (result_if.out_green !== owed_px[CH_GREEN]) begin
          $error("out_green: expected %0d, actual %0d", owed_px[CH_GREEN],
                 result_if.out_green);
          field_errors++;
        end
        if (result_if.out_blue !== owed_px[CH_BLUE]) begin
          $error("out_blue: expected %0d, actual %0d", owed_px[CH_BLUE], result_if.out_blue);
          field_errors++;
        end
      end
    end
  end

  initial begin
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    layers_if.valid    = 1'b0;
    layers_if.l0_red   = '0;
    layers_if.l0_green = '0;
    layers_if.l0_blue  = '0;
    layers_if.l1_red   = '0;
    layers_if.l1_green = '0;
    layers_if.l1_blue  = '0;
    layers_if.l2_red   = '0;
    layers_if.l2_green = '0;
    layers_if.l2_blue  = '0;
    result_if.ready    = 1'b0;
    burst_left = 1;
    gap_left   = 0;
    hold_left  = 0;
    style_left = 0;
    rx_style   = RX_STREAM;
    for (int l = 0; l < NUM_LAYERS_MAX; l++) begin
      mode_sh[l]  = MODE_NORMAL;
      alpha_sh[l] = ALPHA_FULL;
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // The first pixels run with the reset settings: normal mode at full
    // opacity everywhere. Each result should equal the top layer.
    queue_pixel(flat_layers(8'h00, 8'h00, 8'h00));
    queue_pixel(flat_layers(8'hFF, 8'hFF, 8'hFF));
    queue_pixel(flat_layers(8'h55, 8'hAA, 8'h55));
    queue_pixel(rand_layers());
    wait_idle();

    // These settings cover average, multiply and screen, with full, zero and
    // half opacity.
    set_layers(CFG_DATA_W'(MODE_AVERAGE), ALPHA_FULL, CFG_DATA_W'(MODE_MULTIPLY), 7'd0,
               CFG_DATA_W'(MODE_SCREEN), 7'd50);
    queue_pixel(flat_layers(8'h00, 8'h00, 8'h00));
    queue_pixel(flat_layers(8'hFF, 8'hFF, 8'hFF));
    queue_pixel(flat_layers(8'hFF, 8'h00, 8'h80));
    wait_idle();

    // This step covers darken and lighten. Both opacities are above full and
    // must saturate. An unused mode code on the top layer blends as normal.
    set_layers(CFG_DATA_W'(MODE_DARKEN), 7'd127, CFG_DATA_W'(MODE_LIGHTEN), 7'd101,
               7'b0000111, 7'd1);
    queue_pixel(flat_layers(8'hFF, 8'h10, 8'hFF));
    queue_pixel(flat_layers(8'h80, 8'hFF, 8'h00));
    queue_pixel(rand_layers());
    wait_idle();

    // The other unused mode code is written with its upper data bits set.
    // Screen is also written with a stray upper bit.
    set_layers(7'b1111110, 7'd0, 7'b0001011, ALPHA_FULL, CFG_DATA_W'(MODE_MULTIPLY), 7'd99);
    queue_pixel(flat_layers(8'hFF, 8'h40, 8'hFF));
    queue_pixel(flat_layers(8'h00, 8'hFF, 8'h01));
    queue_pixel(rand_layers());
    wait_idle();

    set_layers(CFG_DATA_W'(MODE_LIGHTEN), 7'd50, CFG_DATA_W'(MODE_MULTIPLY), 7'd50,
               CFG_DATA_W'(MODE_AVERAGE), 7'd50);
    queue_pixel(flat_layers(8'hFF, 8'hFF, 8'h00));
    queue_pixel(flat_layers(8'hC3, 8'h3C, 8'hFF));
    queue_pixel(rand_layers());
    wait_idle();

    // In the random part every phase gets a fresh random setting and a
    // batch of random pixels.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      random_setting();
      repeat (PHASE_PIXELS) queue_pixel(rand_layers());
      wait_idle();
    end

    // This pause gives the block time to send anything it should not.
    repeat (4 * LAYER_COUNT) @(negedge clk);

    $display("checked %0d composited pixels under %0d layer settings, %0d long output hold-offs",
             pixels_out, settings_cnt, holds_done);
    $display("%0d field mismatches, %0d results with nothing expected",
             field_errors, stray_results);
    if (field_errors == 0 && stray_results == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // This is the backstop against a hung handshake or a lost result.
  initial begin
    repeat (TIMEOUT_CYCLES) @(posedge clk);
    $display("timeout with %0d pixels accepted and %0d results still owed",
             pixels_in, expected_px_q.size());
    $display("status: fail");
    $finish;
  end

endmodule
